@@ rtl/odd_multiplier_inverse_and_order_assert.svh @@
// assertion macros used by the port-level checker
`ifndef ODD_MULTIPLIER_INVERSE_AND_ORDER_ASSERT_SVH
`define ODD_MULTIPLIER_INVERSE_AND_ORDER_ASSERT_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define OMIO_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define OMIO_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/omio_pkg.sv @@
// shared types and constants for the odd multiplier inverse and order block
package omio_pkg;

  localparam int unsigned ValueW      = 64;
  localparam int unsigned HalfW       = ValueW / 2;
  localparam int unsigned WideRounds   = 61;
  localparam int unsigned NarrowRounds = 29;
  localparam int unsigned NewtonSteps  = 5;
  localparam int unsigned RoundW       = $clog2(WideRounds);
  localparam int unsigned StepW        = $clog2(NewtonSteps);

  localparam logic [RoundW-1:0] WideLast   = RoundW'(WideRounds - 1);
  localparam logic [RoundW-1:0] NarrowLast = RoundW'(NarrowRounds - 1);
  localparam logic [StepW-1:0]  NewtonLast = StepW'(NewtonSteps - 1);
  localparam logic [ValueW-1:0] NewtonTwo  = ValueW'(2);

  // partial product being formed by the shared multiplier
  typedef enum logic [1:0] {
    MUL_LL,
    MUL_HL,
    MUL_LH
  } omio_mul_step_e;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ_GO,
    ST_SQ_WAIT,
    ST_NT1_GO,
    ST_NT1_WAIT,
    ST_NT2_GO,
    ST_NT2_WAIT,
    ST_FINISH
  } omio_state_e;

  // request to the shared multiplier
  typedef struct packed {
    logic start;
    logic square;
  } omio_mul_ctl_t;

endpackage

@@ rtl/omio_mul.sv @@
// shared 64x64 mod 2^64 multiplier built on one 32x32 multiplier, one partial product a cycle
module omio_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  omio_pkg::omio_mul_ctl_t       ctl_i,
  input  logic [omio_pkg::ValueW-1:0]   op_a_i,
  input  logic [omio_pkg::ValueW-1:0]   op_b_i,
  output logic                          done_o,
  output logic [omio_pkg::ValueW-1:0]   res_o
);
  import omio_pkg::*;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic                sq_q, sq_d;
  omio_mul_step_e      step_q, step_d;
  logic [ValueW-1:0]   a_q, a_d, b_q, b_d, acc_q, acc_d;
  logic [HalfW-1:0]    mul_a, mul_b, cross_term;
  logic [ValueW-1:0]   prod;

  // operand halves for the current partial product
  always_comb begin
    unique case (step_q)
      MUL_LL: begin
        mul_a = a_q[HalfW-1:0];
        mul_b = b_q[HalfW-1:0];
      end
      MUL_HL: begin
        mul_a = a_q[ValueW-1:HalfW];
        mul_b = b_q[HalfW-1:0];
      end
      default: begin
        mul_a = a_q[HalfW-1:0];
        mul_b = b_q[ValueW-1:HalfW];
      end
    endcase
  end

  // the single 32x32 multiplier; cross terms only feed the upper half
  assign prod       = ValueW'(mul_a) * ValueW'(mul_b);
  assign cross_term = sq_q ? {prod[HalfW-2:0], 1'b0} : prod[HalfW-1:0];

  // step sequencing and accumulation
  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    sq_d   = sq_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (ctl_i.start) begin
      busy_d = 1'b1;
      step_d = MUL_LL;
      sq_d   = ctl_i.square;
      a_d    = op_a_i;
      b_d    = op_b_i;
    end else if (busy_q) begin
      if (step_q == MUL_LL) begin
        acc_d = prod;
      end else begin
        acc_d = {acc_q[ValueW-1:HalfW] + cross_term, acc_q[HalfW-1:0]};
      end
      unique case (step_q)
        MUL_LL: step_d = MUL_HL;
        MUL_HL: begin
          if (sq_q) begin
            busy_d = 1'b0;
            done_d = 1'b1;
          end else begin
            step_d = MUL_LH;
          end
        end
        default: begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= MUL_LL;
      sq_q   <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
      sq_q   <= sq_d;
    end
  end

  // operands and accumulator
  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign res_o  = acc_q;

endmodule

@@ rtl/odd_multiplier_inverse_and_order.sv @@
// top level: sequencer for the order test and the Newton inverse around the shared multiplier
//
// Input stream: s_axis_tdata carries the 64-bit multiplier candidate, s_axis_tuser
// the narrow flag (1 = order test on the low 32 bits modulo 2^32, 29 squarings;
// 0 = order test modulo 2^64, 61 squarings). The block takes one request at a time.
// Output stream: m_axis_tdata carries the inverse modulo 2^64 (meaningful for an
// odd candidate), m_axis_tuser the maximal-order flag.
// Every 64-bit product goes through one 32x32 multiplier, one partial product a
// cycle: a squaring takes two partial products, a general product three. The
// order test stops at the first square that is 0 or 1, then five Newton steps
// of two products each follow. The next request is taken once the sequencer
// has handed the result on and is back in idle.
// The result sits in an output register: a new request is accepted while it
// still waits; a stalled receiver only holds up the block when the next
// result is finished. Reset clears the sequencer and drops m_axis_tvalid.
module odd_multiplier_inverse_and_order (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [omio_pkg::ValueW-1:0] s_axis_tdata,   // [63:0] value
  input  logic                        s_axis_tuser,   // [0] narrow
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [omio_pkg::ValueW-1:0] m_axis_tdata,   // [63:0] inverse
  output logic                        m_axis_tuser    // [0] max_order
);
  import omio_pkg::*;

  omio_state_e        state_q, state_d;
  logic [RoundW-1:0]  rnd_q, rnd_d;
  logic [StepW-1:0]   nt_q, nt_d;
  logic               narrow_q, narrow_d;
  logic               ok_q, ok_d;
  logic               m_valid_q, m_valid_d;
  logic [ValueW-1:0]  a_q, a_d, x_q, x_d, v_q, v_d, d_q, d_d;
  logic [ValueW-1:0]  out_inv_q, out_inv_d;
  logic               out_ok_q, out_ok_d;
  logic [ValueW-1:0]  sq, mul_a, mul_b, mul_res;
  logic               mul_done;
  omio_mul_ctl_t      mul_ctl;

  // square result trimmed to the tested width
  assign sq = narrow_q ? {{HalfW{1'b0}}, mul_res[HalfW-1:0]} : mul_res;

  // sequencer: next state, datapath updates and multiplier requests
  always_comb begin
    state_d   = state_q;
    rnd_d     = rnd_q;
    nt_d      = nt_q;
    narrow_d  = narrow_q;
    ok_d      = ok_q;
    a_d       = a_q;
    x_d       = x_q;
    v_d       = v_q;
    d_d       = d_q;
    out_inv_d = out_inv_q;
    out_ok_d  = out_ok_q;
    m_valid_d = m_valid_q && !m_axis_tready;
    mul_ctl   = '0;
    mul_a     = v_q;
    mul_b     = v_q;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          a_d      = s_axis_tdata;
          x_d      = s_axis_tdata;
          narrow_d = s_axis_tuser;
          v_d      = s_axis_tuser ? {{HalfW{1'b0}}, s_axis_tdata[HalfW-1:0]} : s_axis_tdata;
          ok_d     = 1'b1;
          rnd_d    = '0;
          nt_d     = '0;
          state_d  = ST_SQ_GO;
        end
      end
      ST_SQ_GO: begin
        mul_ctl.start  = 1'b1;
        mul_ctl.square = 1'b1;
        state_d        = ST_SQ_WAIT;
      end
      ST_SQ_WAIT: begin
        if (mul_done) begin
          v_d = sq;
          if (sq[ValueW-1:1] == '0) begin
            ok_d    = 1'b0;
            state_d = ST_NT1_GO;
          end else if (rnd_q == (narrow_q ? NarrowLast : WideLast)) begin
            state_d = ST_NT1_GO;
          end else begin
            rnd_d   = rnd_q + RoundW'(1);
            state_d = ST_SQ_GO;
          end
        end
      end
      ST_NT1_GO: begin
        mul_ctl.start = 1'b1;
        mul_a         = a_q;
        mul_b         = x_q;
        state_d       = ST_NT1_WAIT;
      end
      ST_NT1_WAIT: begin
        if (mul_done) begin
          d_d     = NewtonTwo - mul_res;
          state_d = ST_NT2_GO;
        end
      end
      ST_NT2_GO: begin
        mul_ctl.start = 1'b1;
        mul_a         = x_q;
        mul_b         = d_q;
        state_d       = ST_NT2_WAIT;
      end
      ST_NT2_WAIT: begin
        if (mul_done) begin
          x_d = mul_res;
          if (nt_q == NewtonLast) begin
            state_d = ST_FINISH;
          end else begin
            nt_d    = nt_q + StepW'(1);
            state_d = ST_NT1_GO;
          end
        end
      end
      default: begin
        // hand the result to the output register once it is free
        if (!m_valid_q || m_axis_tready) begin
          out_inv_d = x_q;
          out_ok_d  = ok_q;
          m_valid_d = 1'b1;
          state_d   = ST_IDLE;
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      rnd_q     <= '0;
      nt_q      <= '0;
      narrow_q  <= 1'b0;
      ok_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rnd_q     <= rnd_d;
      nt_q      <= nt_d;
      narrow_q  <= narrow_d;
      ok_q      <= ok_d;
      m_valid_q <= m_valid_d;
    end
  end

  // datapath and output payload
  always_ff @(posedge clk_i) begin
    a_q       <= a_d;
    x_q       <= x_d;
    v_q       <= v_d;
    d_q       <= d_d;
    out_inv_q <= out_inv_d;
    out_ok_q  <= out_ok_d;
  end

  // shared multiplier
  omio_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .done_o (mul_done),
    .res_o  (mul_res)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = out_inv_q;
  assign m_axis_tuser  = out_ok_q;

endmodule

@@ rtl/omio_checker.sv @@
// port-level checker for the odd multiplier inverse and order block, with its bind
`include "odd_multiplier_inverse_and_order_assert.svh"

module omio_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        s_axis_tvalid,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [omio_pkg::ValueW-1:0] m_axis_tdata,
  input logic                        m_axis_tuser
);
  import omio_pkg::*;

  logic s_req;
  logic m_stall;

  assign s_req   = s_axis_tvalid && s_axis_tready;
  assign m_stall = m_axis_tvalid && !m_axis_tready;

  // a stalled result holds its payload
  `OMIO_ASSERT_NXT(a_out_hold, m_stall,
    m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  // a result leaves only through a handshake
  `OMIO_ASSERT_IMP(a_out_drop, $fell(m_axis_tvalid), $past(m_axis_tready),
    "result dropped without handshake")

  // a request keeps the block busy for the first cycles of its work
  `OMIO_ASSERT_IMP(a_busy_after_req, s_req, ##1 !s_axis_tready ##2 !s_axis_tready,
    "request taken while busy")

  // a new result appears only when the block was working
  `OMIO_ASSERT_IMP(a_result_from_work, $rose(m_axis_tvalid), $past(!s_axis_tready),
    "result appeared from idle")

endmodule

bind odd_multiplier_inverse_and_order omio_checker u_omio_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
